// File: sv/mxt_pkg.sv
// ============================================================================
// mxt_pkg - shared definitions for the maximum subarray XOR trie block
// Widths, node layout and the command and status bundles passed between
// the controller and the datapath.
// ============================================================================
package mxt_pkg;

    localparam int DATA_W     = 31;
    localparam int KEY_BITS   = 31;
    localparam int NODE_COUNT = 32768;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int USED_W = NODE_W + 1;
    localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int NEED_W = $clog2(KEY_BITS + 1);

    localparam logic [DATA_W-1:0] KEY_MASK = DATA_W'((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(KEY_BITS - 1);

    typedef logic [NODE_W-1:0] node_idx_t;

    // A child link of zero means no child; the root is never a child.
    typedef struct packed {
        node_idx_t kid1;
        node_idx_t kid0;
    } node_t;

    typedef struct packed {
        logic load;
        logic start;
        logic init_walk;
        logic zero_key;
        logic q_step;
        logic i_step;
        logic f_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic q_done;
        logic i_missing;
        logic i_fits;
        logic i_last;
        logic f_last;
    } status_t;

endpackage

// File: sv/mxt_ctrl.sv
// ============================================================================
// mxt_ctrl - sequencing controller
// Steps each item through an optional zero insert, the query walk, the
// insert walk, the fill of new nodes and the hand-over to the output register.
// ============================================================================
module mxt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            start_new,
    input  logic            out_stall,
    input  mxt_pkg::status_t sts,
    output logic            in_stall,
    output logic            out_valid,
    output mxt_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_QRY  = 5'b00010,
        S_INS  = 5'b00100,
        S_FILL = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   zero_pass_reg;
    logic   zero_pass_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   ins_done;

    always_comb
    begin
        state_next     = state_reg;
        zero_pass_next = zero_pass_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        ins_done       = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.start      = start_new;
                    cmd.init_walk  = 1'b1;
                    cmd.zero_key   = start_new;
                    zero_pass_next = start_new;
                    state_next     = start_new ? S_INS : S_QRY;
                end
            end
            S_QRY:
            begin
                cmd.q_step = 1'b1;
                if (sts.q_done)
                begin
                    cmd.init_walk = 1'b1;
                    state_next    = S_INS;
                end
            end
            S_INS:
            begin
                cmd.i_step = 1'b1;
                if (sts.i_missing)
                begin
                    if (sts.i_fits)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        ins_done = 1'b1;
                    end
                end
                else if (sts.i_last)
                begin
                    ins_done = 1'b1;
                end
            end
            S_FILL:
            begin
                cmd.f_step = 1'b1;
                if (sts.f_last)
                begin
                    ins_done = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // After the zero prefix of a new run is in, the item's own walks follow.
        if (ins_done)
        begin
            if (zero_pass_reg)
            begin
                cmd.init_walk  = 1'b1;
                cmd.zero_key   = 1'b0;
                zero_pass_next = 1'b0;
                state_next     = S_QRY;
            end
            else
            begin
                state_next = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            zero_pass_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zero_pass_reg <= zero_pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: sv/mxt_dpath.sv
// ============================================================================
// mxt_dpath - trie datapath
// Holds the node memory, the root node, the prefix, the running maximum and
// the walk registers; one trie level is visited per cycle.
// ============================================================================
module mxt_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mxt_pkg::cmd_t                 cmd,
    input  logic [mxt_pkg::DATA_W-1:0]    value,
    output mxt_pkg::status_t              sts,
    output logic [mxt_pkg::DATA_W-1:0]    best_xor,
    output logic                          store_full
);

    mxt_pkg::node_t node_mem [mxt_pkg::NODE_COUNT];

    logic [mxt_pkg::DATA_W-1:0] prefix_reg;
    logic [mxt_pkg::DATA_W-1:0] best_reg;
    logic                       full_reg;
    logic [mxt_pkg::USED_W-1:0] used_reg;
    mxt_pkg::node_t             root_reg;

    logic [mxt_pkg::DATA_W-1:0] key_reg;
    logic [mxt_pkg::LVL_W-1:0]  lvl_reg;
    logic [mxt_pkg::DATA_W-1:0] cand_reg;
    mxt_pkg::node_idx_t         cur_reg;
    logic                       at_root_reg;
    mxt_pkg::node_t             rd_data_reg;

    logic [mxt_pkg::DATA_W-1:0] out_best_reg;
    logic                       out_full_reg;

    logic [mxt_pkg::DATA_W-1:0]   prefix_new;
    logic [mxt_pkg::DATA_W-1:0]   key_src;
    mxt_pkg::node_t               node_cur;
    logic [mxt_pkg::DATA_W-1:0]   key_shift;
    logic [mxt_pkg::DATA_W-1:0]   fill_shift;
    logic [mxt_pkg::LVL_W-1:0]    lvl_m1;
    logic                         key_bit;
    logic                         fill_bit;
    mxt_pkg::node_idx_t           kid_same;
    mxt_pkg::node_idx_t           kid_opp;
    logic                         has_same;
    logic                         has_opp;
    logic                         q_dead;
    mxt_pkg::node_idx_t           q_next;
    logic                         lvl_zero;
    logic [mxt_pkg::DATA_W-1:0]   cand_full;
    logic [mxt_pkg::NEED_W-1:0]   need;
    logic [mxt_pkg::USED_W:0]     fits_sum;
    logic                         i_fits;
    logic [mxt_pkg::USED_W-1:0]   used_plus1;
    mxt_pkg::node_t               br_node;
    mxt_pkg::node_t               fill_node;
    logic                         mem_we;
    mxt_pkg::node_idx_t           mem_waddr;
    mxt_pkg::node_t               mem_wdata;
    logic                         mem_re;
    mxt_pkg::node_idx_t           mem_raddr;

    always_comb
    begin
        prefix_new = (cmd.start ? '0 : prefix_reg) ^ value;
        key_src    = (cmd.load ? prefix_new : prefix_reg) & mxt_pkg::KEY_MASK;
        node_cur   = at_root_reg ? root_reg : rd_data_reg;

        key_shift  = key_reg >> lvl_reg;
        key_bit    = key_shift[0];
        lvl_m1     = lvl_reg - 1'b1;
        fill_shift = key_reg >> lvl_m1;
        fill_bit   = fill_shift[0];
        lvl_zero   = (lvl_reg == '0);

        kid_same = key_bit ? node_cur.kid1 : node_cur.kid0;
        kid_opp  = key_bit ? node_cur.kid0 : node_cur.kid1;
        has_same = (kid_same != '0);
        has_opp  = (kid_opp != '0);
        q_dead   = !has_same && !has_opp;
        q_next   = has_opp ? kid_opp : kid_same;

        // Each level where the opposite branch is taken contributes a one to the XOR.
        cand_full = cand_reg | (has_opp ? (mxt_pkg::DATA_W'(1) << lvl_reg) : '0);

        // A path that breaks off at this level needs one new node per remaining level.
        need     = mxt_pkg::NEED_W'(lvl_reg) + 1'b1;
        fits_sum = (mxt_pkg::USED_W + 1)'(used_reg) + (mxt_pkg::USED_W + 1)'(need);
        i_fits   = (fits_sum <= (mxt_pkg::USED_W + 1)'(mxt_pkg::NODE_COUNT));

        used_plus1 = used_reg + 1'b1;

        br_node = node_cur;
        if (key_bit)
        begin
            br_node.kid1 = mxt_pkg::NODE_W'(used_reg);
        end
        else
        begin
            br_node.kid0 = mxt_pkg::NODE_W'(used_reg);
        end

        fill_node = '0;
        if (!lvl_zero)
        begin
            if (fill_bit)
            begin
                fill_node.kid1 = mxt_pkg::NODE_W'(used_plus1);
            end
            else
            begin
                fill_node.kid0 = mxt_pkg::NODE_W'(used_plus1);
            end
        end

        mem_we    = (cmd.i_step && !has_same && i_fits && !at_root_reg) || cmd.f_step;
        mem_waddr = cmd.f_step ? mxt_pkg::NODE_W'(used_reg) : cur_reg;
        mem_wdata = cmd.f_step ? fill_node : br_node;
        mem_re    = (cmd.q_step && !q_dead) || (cmd.i_step && has_same);
        mem_raddr = cmd.q_step ? q_next : kid_same;

        sts.q_done    = q_dead || lvl_zero;
        sts.i_missing = !has_same;
        sts.i_fits    = i_fits;
        sts.i_last    = lvl_zero;
        sts.f_last    = lvl_zero;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= node_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg  <= '0;
            best_reg    <= '0;
            full_reg    <= 1'b0;
            used_reg    <= mxt_pkg::USED_W'(1);
            root_reg    <= '0;
            at_root_reg <= 1'b1;
        end
        else
        begin
            if (cmd.load)
            begin
                prefix_reg <= prefix_new;
                if (cmd.start)
                begin
                    best_reg <= '0;
                    full_reg <= 1'b0;
                    used_reg <= mxt_pkg::USED_W'(1);
                    root_reg <= '0;
                end
            end

            if (cmd.q_step && lvl_zero && !q_dead && (cand_full > best_reg))
            begin
                best_reg <= cand_full;
            end

            if (cmd.i_step && !has_same)
            begin
                if (!i_fits)
                begin
                    full_reg <= 1'b1;
                end
                else if (at_root_reg)
                begin
                    root_reg <= br_node;
                end
            end

            if (cmd.f_step)
            begin
                used_reg <= used_plus1;
            end

            if (cmd.init_walk)
            begin
                at_root_reg <= 1'b1;
            end
            else if ((cmd.q_step && !q_dead) || (cmd.i_step && has_same))
            begin
                at_root_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_walk)
        begin
            key_reg  <= cmd.zero_key ? '0 : key_src;
            lvl_reg  <= mxt_pkg::LVL_TOP;
            cand_reg <= '0;
        end
        else if (cmd.q_step)
        begin
            cur_reg  <= q_next;
            lvl_reg  <= lvl_m1;
            cand_reg <= cand_full;
        end
        else if (cmd.i_step)
        begin
            if (has_same)
            begin
                cur_reg <= kid_same;
                lvl_reg <= lvl_m1;
            end
        end
        else if (cmd.f_step)
        begin
            lvl_reg <= lvl_m1;
        end

        if (cmd.out_load)
        begin
            out_best_reg <= best_reg;
            out_full_reg <= full_reg;
        end
    end

    assign best_xor   = out_best_reg;
    assign store_full = out_full_reg;

endmodule

// File: sv/max_xor_subarray_trie.sv
// ============================================================================
// max_xor_subarray_trie - running maximum subarray XOR over a value stream
// Keeps prefix XORs since the last start in a binary trie, space allowing,
// and reports the largest XOR of any two stored prefixes after each value.
// ============================================================================
// Usage:
// The input channel (in_valid, in_stall, value, start_new) takes one value per
// transfer; start_new clears the trie, prefix, maximum and full flag first.
// The output channel (out_valid, out_stall, best_xor, store_full) returns one
// result per input transfer, in order.
// Each item runs a query walk followed by an insert walk and a node fill,
// one trie level per cycle through the single-port node memory, and then
// loads the output register. The next value is taken only once the result
// is loaded; a start item first inserts the zero prefix.
// One item is worked on at a time; in_stall is high while it is in flight.
// The result sits in an output register, so the next value is taken while
// a stalled result waits; a further result then holds until it is taken.
// After reset the trie is empty (not even the zero prefix), the node memory
// needs no clearing, and the block is ready straight out of reset.
// ============================================================================
module max_xor_subarray_trie (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [mxt_pkg::DATA_W-1:0] value,
    input  logic                       start_new,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [mxt_pkg::DATA_W-1:0] best_xor,
    output logic                       store_full
);

    mxt_pkg::cmd_t    cmd;
    mxt_pkg::status_t sts;

    mxt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .start_new (start_new),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mxt_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .sts        (sts),
        .best_xor   (best_xor),
        .store_full (store_full)
    );

endmodule

// File: sv/mxt_checker.sv
// ============================================================================
// mxt_checker - port-level checks for the maximum subarray XOR trie
// Tracks transfers in flight and checks result hold, input stall and bounds.
// ============================================================================
module mxt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [mxt_pkg::DATA_W-1:0] best_xor,
    input logic                       store_full
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign cnt_next = cnt_reg + 2'(in_xfer) - 2'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_xor) && $stable(store_full))
        else $error("stalled result changed or vanished");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("input not stalled while an item is being processed");

    // A result may only be shown for an input transfer not yet answered.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 2'd0)
        else $error("result presented with no item outstanding");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> cnt_reg <= 2'd1)
        else $error("input taken with two items already outstanding");

endmodule

bind max_xor_subarray_trie mxt_checker u_mxt_checker (.*);

// File: tb/max_xor_subarray_trie_tb.sv
// ============================================================================
// max_xor_subarray_trie_tb - self-checking bench for the subarray XOR trie
// Streams directed and random values through the block and tracks the running
// prefix trie alongside it, checking every result transfer against the
// expected maximum XOR and full flag. One long session fills the node table.
// ============================================================================
module max_xor_subarray_trie_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                        CYCLE_LIMIT = 1_200_000;
    localparam logic [mxt_pkg::DATA_W-1:0] ALL_ONES   = '1;

    typedef struct packed {
        logic [mxt_pkg::DATA_W-1:0] best_xor;
        logic                       store_full;
    } result_t;

    // Keeps its own copy of the prefix trie and the queue of results due.
    class best_xor_tracker;
        int unsigned                kid0 [mxt_pkg::NODE_COUNT];
        int unsigned                kid1 [mxt_pkg::NODE_COUNT];
        int unsigned                nodes_used;
        logic [mxt_pkg::DATA_W-1:0] prefix;
        logic [mxt_pkg::DATA_W-1:0] best;
        logic                       full;
        result_t                    due_results [$];
        int unsigned                mismatches;

        function new();
            nodes_used = 1;
            prefix     = '0;
            best       = '0;
            full       = 1'b0;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return due_results.size();
        endfunction

        task flag_mismatch(input string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // The path is only added when every node it still lacks is free.
        function void insert_prefix(input logic [mxt_pkg::DATA_W-1:0] key);
            int unsigned n;
            int unsigned c;
            int unsigned fresh;
            bit          diverged;
            n        = 0;
            fresh    = 0;
            diverged = 1'b0;
            for (int lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--)
            begin
                if (!diverged)
                begin
                    c = key[lvl] ? kid1[n] : kid0[n];
                    if (c == 0)
                        diverged = 1'b1;
                    else
                        n = c;
                end
                if (diverged)
                    fresh++;
            end
            if (nodes_used + fresh > mxt_pkg::NODE_COUNT)
            begin
                full = 1'b1;
                return;
            end
            n = 0;
            for (int lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--)
            begin
                c = key[lvl] ? kid1[n] : kid0[n];
                if (c == 0)
                begin
                    c = nodes_used;
                    nodes_used++;
                    kid0[c] = 0;
                    kid1[c] = 0;
                    if (key[lvl])
                        kid1[n] = c;
                    else
                        kid0[n] = c;
                end
                n = c;
            end
        endfunction

        // Greedy walk towards the opposite bit; fails only on an empty trie.
        function bit best_partner(input logic [mxt_pkg::DATA_W-1:0] key,
                                  output logic [mxt_pkg::DATA_W-1:0] gain);
            int unsigned                n;
            int unsigned                c;
            logic                       want;
            logic [mxt_pkg::DATA_W-1:0] found;
            n     = 0;
            found = '0;
            for (int lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--)
            begin
                want = ~key[lvl];
                c    = want ? kid1[n] : kid0[n];
                if (c == 0)
                begin
                    want = key[lvl];
                    c    = want ? kid1[n] : kid0[n];
                    if (c == 0)
                        return 1'b0;
                end
                found[lvl] = want;
                n          = c;
            end
            gain = found ^ key;
            return 1'b1;
        endfunction

        function void take_value(input logic [mxt_pkg::DATA_W-1:0] v, input logic s);
            logic [mxt_pkg::DATA_W-1:0] key;
            logic [mxt_pkg::DATA_W-1:0] gain;
            result_t                    due;
            if (s)
            begin
                kid0[0]    = 0;
                kid1[0]    = 0;
                nodes_used = 1;
                prefix     = '0;
                best       = '0;
                full       = 1'b0;
                insert_prefix('0);
            end
            prefix = prefix ^ v;
            key    = prefix & mxt_pkg::KEY_MASK;
            if (best_partner(key, gain))
            begin
                if (gain > best)
                    best = gain;
            end
            insert_prefix(key);
            due.best_xor   = best;
            due.store_full = full;
            due_results    = {due_results, due};
        endfunction

        task check_result(input logic [mxt_pkg::DATA_W-1:0] got_best,
                          input logic got_full);
            result_t want;
            if (due_results.size() == 0)
            begin
                flag_mismatch($sformatf("result %h/%b with no value outstanding",
                                        got_best, got_full));
                return;
            end
            want = due_results.pop_front();
            if (got_best !== want.best_xor)
                flag_mismatch($sformatf("best_xor %h, expected %h",
                                        got_best, want.best_xor));
            if (got_full !== want.store_full)
                flag_mismatch($sformatf("store_full %b, expected %b",
                                        got_full, want.store_full));
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [mxt_pkg::DATA_W-1:0] value;
    logic                       start_new;
    logic                       out_valid;
    logic                       out_stall;
    logic [mxt_pkg::DATA_W-1:0] best_xor;
    logic                       store_full;

    best_xor_tracker            book;
    bit                         send_gaps;
    bit                         recv_gaps;
    int                         hold_left;
    int                         session_left;
    logic [mxt_pkg::DATA_W-1:0] last_value;
    int unsigned                cycles;

    max_xor_subarray_trie dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .start_new  (start_new),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_xor   (best_xor),
        .store_full (store_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_result(best_xor, store_full);
    end

    // Receiver: random or no stalls, or a counted hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (recv_gaps)
                out_stall = ($urandom_range(99) < 33);
            else
                out_stall = 1'b0;
        end
    end

    // Called at a falling edge; returns at a falling edge with valid low.
    task automatic offer(input logic [mxt_pkg::DATA_W-1:0] v, input logic s);
        int          gap;
        logic [31:0] noise;
        gap = 0;
        if (send_gaps)
        begin
            if ($urandom_range(99) < 5)
                gap = $urandom_range(1, 90);
            else
                while ($urandom_range(99) < 33)
                    gap++;
        end
        repeat (gap)
        begin
            noise     = $urandom;
            in_valid  = 1'b0;
            value     = noise[mxt_pkg::DATA_W-1:0];
            start_new = noise[31];
            @(negedge clk);
        end
        in_valid  = 1'b1;
        value     = v;
        start_new = s;
        do
            @(posedge clk);
        while (in_stall);
        book.take_value(v, s);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Short sessions, each opened by a start transfer, with mixed content.
    task automatic random_sessions(input int count);
        logic [31:0]                r;
        logic [mxt_pkg::DATA_W-1:0] v;
        logic                       s;
        repeat (count)
        begin
            s = 1'b0;
            if (session_left == 0)
            begin
                session_left = $urandom_range(1, 40);
                s            = 1'b1;
            end
            session_left--;
            r = $urandom;
            case ($urandom_range(3))
                0: v = r[mxt_pkg::DATA_W-1:0];
                1: v = mxt_pkg::DATA_W'($urandom_range(15));
                2: v = r[mxt_pkg::DATA_W-1:0] | 31'h7F00_0000;
                default: v = last_value;
            endcase
            last_value = v;
            offer(v, s);
        end
    endtask

    initial
    begin : stimulus
        logic [mxt_pkg::DATA_W-1:0] lane;
        logic [mxt_pkg::DATA_W-1:0] target;
        logic [10:0]                spread;
        logic [31:0]                r;
        book         = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        value        = '0;
        start_new    = 1'b0;
        send_gaps    = 1'b1;
        recv_gaps    = 1'b1;
        hold_left    = 0;
        session_left = 0;
        last_value   = '0;
        cycles       = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Before any start the trie is empty, so the first walk finds nothing.
        offer('0, 1'b0);
        offer(ALL_ONES, 1'b0);
        offer(31'h5555_5555, 1'b0);
        offer(31'h2AAA_AAAA, 1'b0);
        offer(31'h0000_0001, 1'b0);
        offer(ALL_ONES, 1'b1);
        offer('0, 1'b0);
        offer(ALL_ONES, 1'b0);
        offer('0, 1'b1);
        offer('0, 1'b0);
        offer(31'h4000_0000, 1'b1);
        offer(31'h4000_0000, 1'b0);
        offer(31'h0000_0001, 1'b0);
        offer(31'h3FFF_FFFF, 1'b0);
        offer(31'h1234_5678, 1'b1);
        offer(31'h1234_5678, 1'b0);
        offer(31'h0F0F_0F0F, 1'b0);
        offer(31'h7FFF_FFFE, 1'b1);
        offer(31'h0000_0001, 1'b0);

        random_sessions(40);

        // Long receiver hold-off while values keep coming, then drain fully.
        hold_left = 400;
        send_gaps = 1'b0;
        random_sessions(12);
        send_gaps = 1'b1;
        while (book.outstanding() != 0)
            @(negedge clk);

        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        random_sessions(40);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        random_sessions(20);

        // One long session whose prefixes fan out over the top eleven levels,
        // so the node table runs out a few dozen transfers before the end.
        lane = '0;
        for (int k = 0; k < 1500; k++)
        begin
            for (int b = 0; b < 11; b++)
                spread[b] = k[10 - b];
            r      = $urandom;
            target = {spread, r[19:0]};
            offer(target ^ lane, k == 0);
            lane = target;
        end

        // A fresh start must clear the sticky full flag.
        session_left = 0;
        random_sessions(20);

        while (book.outstanding() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (book.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
